// ----- sv/ipmbr_pkg.sv -----
// shared types and constants of the ipmb request responder
// no dependencies; imported by every module of the block
package ipmbr_pkg;

	// request store and response frame
	localparam int REQ_KEEP  = 5;
	localparam int RESP_LEN  = 10;
	localparam int CNT_W     = 3;
	localparam int POS_W     = 4;
	localparam int ADDR_W    = 7;
	localparam logic [7:0] FILL_BYTE = 8'h55;

	// default depth of the front to back queue
	localparam int QUEUE_DEPTH_DEF = 2;

	// incoming event codes
	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_STOP  = 2'd2,
		CMD_TURN  = 2'd3
	} cmd_t;

	// outgoing bus actions
	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_REQUEST = 3'd1,
		ACT_START   = 3'd2,
		ACT_BYTE    = 3'd3,
		ACT_END     = 3'd4
	} act_t;

	// work for the back end
	typedef enum logic [1:0] {
		OP_NOP   = 2'd0,
		OP_BUILD = 2'd1,
		OP_TURN  = 2'd2
	} op_t;

	// queue entry: operation plus header bytes snapshot taken at stop
	typedef struct packed {
		op_t        op;
		logic       ack;
		logic [7:0] hdr0;
		logic [7:0] hdr1;
		logic [7:0] hdr2;
		logic [7:0] hdr4;
		logic [7:0] hdr5;
	} qent_t;

	// transmit side status
	typedef struct packed {
		logic             sending;
		logic [POS_W-1:0] pos;
	} bstat_t;

endpackage

// ----- sv/ipmbr_front.sv -----
// receive side: accepts events, keeps the request bytes, classifies work
// depends on ipmbr_pkg
module ipmbr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	output logic              s_ready,
	input  ipmbr_pkg::cmd_t   cmd,
	input  logic [7:0]        rx_byte,
	input  logic              ack_ok,
	input  logic              q_full,
	output logic              q_push,
	output ipmbr_pkg::qent_t  q_entry
);
	import ipmbr_pkg::*;

	logic [7:0]       req_q [REQ_KEEP];
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       r0, r2, r3, r4;
	logic [7:0]       b1;
	logic             accept;

	assign s_ready = !q_full;
	assign accept  = s_valid && !q_full;
	assign q_push  = accept;

	// bytes beyond the fill count read as zero
	always_comb begin
		r0 = (cnt_q > CNT_W'(0)) ? req_q[0] : 8'h00;
		r2 = (cnt_q > CNT_W'(2)) ? req_q[2] : 8'h00;
		r3 = (cnt_q > CNT_W'(3)) ? req_q[3] : 8'h00;
		r4 = (cnt_q > CNT_W'(4)) ? req_q[4] : 8'h00;
		b1 = {r0[7:2] + 6'd1, 2'b00};
	end

	// classify and snapshot the response header
	always_comb begin
		q_entry.ack  = ack_ok;
		q_entry.hdr0 = r2;
		q_entry.hdr1 = b1;
		q_entry.hdr2 = 8'h00 - (r2 + b1);
		q_entry.hdr4 = r3 & 8'hfc;
		q_entry.hdr5 = r4;
		case (cmd)
			CMD_STOP: q_entry.op = OP_BUILD;
			CMD_TURN: q_entry.op = OP_TURN;
			default:  q_entry.op = OP_NOP;
		endcase
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (cmd == CMD_START) begin
				cnt_q <= '0;
			end else if (cmd == CMD_DATA && cnt_q < CNT_W'(REQ_KEEP)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// request byte store
	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_DATA && cnt_q < CNT_W'(REQ_KEEP)) begin
			req_q[cnt_q] <= rx_byte;
		end
	end

endmodule

// ----- sv/ipmbr_fifo.sv -----
// short queue of work entries between receive and transmit sides
// depends on ipmbr_pkg
module ipmbr_fifo #(
	parameter int DEPTH = ipmbr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ipmbr_pkg::qent_t  din,
	output logic              full,
	input  logic              pop,
	output ipmbr_pkg::qent_t  dout,
	output logic              empty
);
	import ipmbr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W_Q = $clog2(DEPTH + 1);

	qent_t              mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;

	assign full  = (count_q == CNT_W_Q'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W_Q'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W_Q'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ----- sv/ipmbr_back.sv -----
// transmit side: builds the response, walks it out one bus turn at a time
// depends on ipmbr_pkg
module ipmbr_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ipmbr_pkg::ADDR_W-1:0]   cfg_wr_data,
	input  logic                           q_empty,
	input  ipmbr_pkg::qent_t               q_entry,
	output logic                           q_pop,
	output logic                           m_valid,
	input  logic                           m_ready,
	output ipmbr_pkg::act_t                m_action,
	output logic [7:0]                     m_byte,
	output ipmbr_pkg::bstat_t              status
);
	import ipmbr_pkg::*;

	logic [ADDR_W-1:0] own_address_q;
	logic [7:0]        resp_q [RESP_LEN];
	logic              sending_q, sending_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic              build;
	act_t              act_d;
	logic [7:0]        byte_d;
	logic [7:0]        b3, b9;
	logic              out_valid_q;
	act_t              out_action_q;
	logic [7:0]        out_byte_q;

	assign q_pop          = !q_empty && (!out_valid_q || m_ready);
	assign m_valid        = out_valid_q;
	assign m_action       = out_action_q;
	assign m_byte         = out_byte_q;
	assign status.sending = sending_q;
	assign status.pos     = pos_q;

	// trailing checksum over bytes three to eight; hdr0, hdr1 and hdr2 sum to zero
	assign b3 = {1'b0, own_address_q};
	assign b9 = 8'h00 - (b3 + q_entry.hdr4 + q_entry.hdr5 + FILL_BYTE);

	// execute one queued operation
	always_comb begin
		act_d     = ACT_NONE;
		byte_d    = 8'h00;
		sending_d = sending_q;
		pos_d     = pos_q;
		build     = 1'b0;
		case (q_entry.op)
			OP_BUILD: begin
				if (!sending_q) begin
					build     = 1'b1;
					sending_d = 1'b1;
					pos_d     = '0;
					act_d     = ACT_REQUEST;
				end
			end
			OP_TURN: begin
				if (sending_q) begin
					if (!q_entry.ack || pos_q >= POS_W'(RESP_LEN)) begin
						sending_d = 1'b0;
						pos_d     = '0;
						act_d     = ACT_END;
					end else if (pos_q == '0) begin
						byte_d = resp_q[0];
						pos_d  = POS_W'(1);
						act_d  = ACT_START;
					end else begin
						byte_d = resp_q[pos_q];
						pos_d  = pos_q + POS_W'(1);
						act_d  = ACT_BYTE;
					end
				end
			end
			default: ;
		endcase
	end

	// own address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= '0;
		end else if (cfg_wr_en) begin
			own_address_q <= cfg_wr_data;
		end
	end

	// transfer state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sending_q    <= 1'b0;
			pos_q        <= '0;
			out_valid_q  <= 1'b0;
			out_action_q <= ACT_NONE;
		end else begin
			if (q_pop) begin
				sending_q    <= sending_d;
				pos_q        <= pos_d;
				out_valid_q  <= 1'b1;
				out_action_q <= act_d;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output byte
	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_byte_q <= byte_d;
		end
	end

	// response frame store, written whole on a build
	always_ff @(posedge clk) begin
		if (q_pop && build) begin
			resp_q[0] <= {1'b0, q_entry.hdr0[7:1]};
			resp_q[1] <= q_entry.hdr1;
			resp_q[2] <= q_entry.hdr2;
			resp_q[3] <= b3;
			resp_q[4] <= q_entry.hdr4;
			resp_q[5] <= q_entry.hdr5;
			resp_q[6] <= 8'h00;
			resp_q[7] <= FILL_BYTE;
			resp_q[8] <= 8'h00;
			resp_q[9] <= b9;
		end
	end

endmodule

// ----- sv/ipmb_request_responder.sv -----
// IPMB request responder: target receive events in, bus master actions out.
// Input stream s_axis: tuser = event code (0 write start, 1 data byte,
//   2 stop, 3 bus turn), tdata = received byte and acknowledge flag.
// Output stream m_axis: one transaction per input transaction, in order;
//   tuser = bus action, tdata = address or data byte (zero otherwise).
// Config: cfg_wr_en/cfg_wr_data set the seven-bit own address; write it only
//   while no transaction is in flight.
// The receive side stores the first five request bytes and snapshots the
//   response header at stop; the transmit side builds the ten-byte response
//   and steps through it, one byte per bus turn, ending early on a NACK.
// Path: an accepted input is written into the queue, then its result is
//   registered in the output register when that register is free.
// Throughput: one transaction per cycle while m_axis_tready is high, set by
//   the single-step transmit executor that pops one queue entry per cycle.
// Stall: a stalled m_axis holds its result; the queue of QUEUE_DEPTH entries
//   then fills and s_axis_tready drops.
// Reset: clears the fill count, queue, transfer state, output valid and action, and address.
module ipmb_request_responder #(
	parameter int QUEUE_DEPTH = ipmbr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [15:0]                   s_axis_tdata,  // [7:0] rx_byte, [8] ack_ok
	input  logic [1:0]                    s_axis_tuser,  // [1:0] command
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [7:0]                    m_axis_tdata,  // [7:0] out_byte
	output logic [2:0]                    m_axis_tuser,  // [2:0] action
	input  logic                          cfg_wr_en,
	input  logic [ipmbr_pkg::ADDR_W-1:0]  cfg_wr_data
);
	import ipmbr_pkg::*;

	logic   q_push, q_pop, q_full, q_empty;
	qent_t  q_in, q_out;
	act_t   action;
	bstat_t status;

	// receive side
	ipmbr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.cmd     (cmd_t'(s_axis_tuser)),
		.rx_byte (s_axis_tdata[7:0]),
		.ack_ok  (s_axis_tdata[8]),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_in)
	);

	// work queue
	ipmbr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_in),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_out),
		.empty  (q_empty)
	);

	// transmit side
	ipmbr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_empty     (q_empty),
		.q_entry     (q_out),
		.q_pop       (q_pop),
		.m_valid     (m_axis_tvalid),
		.m_ready     (m_axis_tready),
		.m_action    (action),
		.m_byte      (m_axis_tdata),
		.status      (status)
	);

	assign m_axis_tuser = action;

	// a data byte shown only mid-transfer, after the start
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && action == ACT_BYTE) |-> (status.sending && status.pos >= POS_W'(2)))
		else $error("data byte outside an active transfer");

	// end of transfer leaves the transmit side idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && action == ACT_END) |-> (!status.sending && status.pos == '0))
		else $error("transfer state not cleared after end");

	// a new result only ever comes from a queued entry
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!q_empty))
		else $error("result produced with empty queue");

endmodule
